// ===== design/rrs_pkg.sv =====
package rrs_pkg;

    typedef enum logic [2:0] {
        ST_FREE     = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_SLEEPING = 3'd3,
        ST_PAUSED   = 3'd4,
        ST_ZOMBIE   = 3'd5
    } thread_state_t;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_SPAWN = 3'd1,
        OP_KILL  = 3'd2,
        OP_SLEEP = 3'd3,
        OP_PAUSE = 3'd4,
        OP_WAKE  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_NOT_USED = 2'd2,
        STAT_DEAD     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_RDC,
        S_T_FIRST,
        S_T_RD,
        S_T_EV,
        S_T_NEXT,
        S_UL_B,
        S_UL_F,
        S_UL_S,
        S_IN_RDC,
        S_IN_F,
        S_IN_BF,
        S_IN_BS,
        S_IN_FC,
        S_QUANT,
        S_SW_RDC,
        S_SW_FIRST,
        S_SW_RD,
        S_SW_EV,
        S_SP_RD,
        S_SP_EV,
        S_TGT_RD,
        S_KILL_EV,
        S_WAKE_EV,
        S_CUR_RD,
        S_CUR_EV,
        S_DIV_WAIT,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic st;
        logic fwd;
        logic bwd;
    } field_mask_t;

    localparam logic [1:0] CFG_QUANTUM   = 2'd0;
    localparam logic [1:0] CFG_TICK_RATE = 2'd1;

    localparam logic [7:0]  QUANTUM_RESET   = 8'd20;
    localparam logic [16:0] TICK_RATE_RESET = 17'd5000;

    localparam int MS_PER_SEC = 1000;

    // Dividing by 1000 is a shift by 3 and then a division by 125, done as a
    // multiply by ceil(2^37 / 125) and a shift by 37. This is exact for any
    // dividend below 2^30.
    localparam logic [30:0] MS_RECIP = 31'd1099511628;

endpackage

// ===== design/round_robin_thread_scheduler_top.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_ready     opcode, slot, sleep_ms, now_ticks, switch_inhibit
// out       out_valid / out_ready   current_slot, switched, start_fresh, new_slot, status_code
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One event at a time. Each memory access is a registered read and each link update a
// separate write, so a tick reads each slot walked and writes the links of each freed
// zombie and each promoted sleeper, and the switch search reads slot by slot; a spawn scans
// the slots upward from 0. A sleep waits for the wake time: one multiply for the product,
// one for the reciprocal of 1000.
// Reset clears the slot valid bits, so the table reads as its reset contents at once.
// A result waiting on out_ready does not block the next input transfer; the block
// stalls only when a second result is ready. cfg_ready is always high.
module round_robin_thread_scheduler_top #(
    parameter int MAX_THREADS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  slot,
    input  logic [15:0] sleep_ms,
    input  logic [31:0] now_ticks,
    input  logic        switch_inhibit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  current_slot,
    output logic        switched,
    output logic        start_fresh,
    output logic [3:0]  new_slot,
    output logic [1:0]  status_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int SW = $clog2(MAX_THREADS);

    logic [7:0]             quantum_reg;
    logic [16:0]            rate_reg;
    logic [SW-1:0]          rd_addr;
    rrs_pkg::thread_state_t rd_state;
    logic [SW-1:0]          rd_fwd;
    logic [SW-1:0]          rd_bwd;
    logic [31:0]            wk_rdata;
    logic                   wr_en;
    logic [SW-1:0]          wr_addr;
    rrs_pkg::field_mask_t   wr_mask;
    rrs_pkg::thread_state_t wr_state;
    logic [SW-1:0]          wr_fwd;
    logic [SW-1:0]          wr_bwd;
    logic                   wk_we;
    logic [31:0]            wk_wdata;
    logic                   div_start;
    logic [15:0]            div_ms;
    logic                   div_done;
    logic [31:0]            div_quot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrs_pkg::QUANTUM_RESET;
            rate_reg    <= rrs_pkg::TICK_RATE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rrs_pkg::CFG_QUANTUM)
                quantum_reg <= cfg_data[7:0];
            else if (cfg_index == rrs_pkg::CFG_TICK_RATE)
                rate_reg <= cfg_data;
        end
    end

    rrs_entry_mem #(.MAX_THREADS(MAX_THREADS), .SW(SW)) u_entry_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_state(rd_state),
        .rd_fwd  (rd_fwd),
        .rd_bwd  (rd_bwd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_mask (wr_mask),
        .wr_state(wr_state),
        .wr_fwd  (wr_fwd),
        .wr_bwd  (wr_bwd)
    );

    rrs_wake_mem #(.MAX_THREADS(MAX_THREADS), .SW(SW)) u_wake_mem (
        .clk    (clk),
        .rd_addr(rd_addr),
        .rd_data(wk_rdata),
        .wr_en  (wk_we),
        .wr_addr(wr_addr),
        .wr_data(wk_wdata)
    );

    rrs_wake_calc u_wake_calc (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .ms   (div_ms),
        .rate (rate_reg),
        .done (div_done),
        .quot (div_quot)
    );

    rrs_ctrl #(.MAX_THREADS(MAX_THREADS), .SW(SW)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .slot          (slot),
        .sleep_ms      (sleep_ms),
        .now_ticks     (now_ticks),
        .switch_inhibit(switch_inhibit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .current_slot  (current_slot),
        .switched      (switched),
        .start_fresh   (start_fresh),
        .new_slot      (new_slot),
        .status_code   (status_code),
        .quantum_ticks (quantum_reg),
        .rd_addr       (rd_addr),
        .rd_state      (rd_state),
        .rd_fwd        (rd_fwd),
        .rd_bwd        (rd_bwd),
        .wk_rdata      (wk_rdata),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_mask       (wr_mask),
        .wr_state      (wr_state),
        .wr_fwd        (wr_fwd),
        .wr_bwd        (wr_bwd),
        .wk_we         (wk_we),
        .wk_wdata      (wk_wdata),
        .div_start     (div_start),
        .div_ms        (div_ms),
        .div_done      (div_done),
        .div_quot      (div_quot)
    );

endmodule

// ===== design/rrs_entry_mem.sv =====
module rrs_entry_mem #(
    parameter int MAX_THREADS = 16,
    parameter int SW          = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SW-1:0]          rd_addr,
    output rrs_pkg::thread_state_t rd_state,
    output logic [SW-1:0]          rd_fwd,
    output logic [SW-1:0]          rd_bwd,
    input  logic                   wr_en,
    input  logic [SW-1:0]          wr_addr,
    input  rrs_pkg::field_mask_t   wr_mask,
    input  rrs_pkg::thread_state_t wr_state,
    input  logic [SW-1:0]          wr_fwd,
    input  logic [SW-1:0]          wr_bwd
);

    localparam int EW     = 3 + 2 * SW;
    localparam int ST_LO  = 2 * SW;
    localparam int FWD_LO = SW;

    logic [EW-1:0]          mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] valid_reg;
    logic [EW-1:0]          rd_data_reg;
    logic [SW-1:0]          rd_addr_reg;
    logic                   rd_valid_reg;
    rrs_pkg::thread_state_t wr_dflt_state;
    rrs_pkg::thread_state_t rd_dflt_state;

    // An entry never written holds its reset value: a self loop, slot 0 running.
    assign wr_dflt_state = (wr_addr == '0) ? rrs_pkg::ST_RUNNING : rrs_pkg::ST_FREE;
    assign rd_dflt_state = (rd_addr_reg == '0) ? rrs_pkg::ST_RUNNING : rrs_pkg::ST_FREE;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_mask.st || !valid_reg[wr_addr])
                mem[wr_addr][EW-1:ST_LO] <= wr_mask.st ? wr_state : wr_dflt_state;
            if (wr_mask.fwd || !valid_reg[wr_addr])
                mem[wr_addr][ST_LO-1:FWD_LO] <= wr_mask.fwd ? wr_fwd : wr_addr;
            if (wr_mask.bwd || !valid_reg[wr_addr])
                mem[wr_addr][FWD_LO-1:0] <= wr_mask.bwd ? wr_bwd : wr_addr;
        end
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_state = rd_valid_reg ? rrs_pkg::thread_state_t'(rd_data_reg[EW-1:ST_LO])
                                   : rd_dflt_state;
    assign rd_fwd   = rd_valid_reg ? rd_data_reg[ST_LO-1:FWD_LO] : rd_addr_reg;
    assign rd_bwd   = rd_valid_reg ? rd_data_reg[FWD_LO-1:0] : rd_addr_reg;

endmodule

// ===== design/rrs_wake_mem.sv =====
module rrs_wake_mem #(
    parameter int MAX_THREADS = 16,
    parameter int SW          = 4
) (
    input  logic          clk,
    input  logic [SW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [31:0]   wr_data
);

    logic [31:0] mem [MAX_THREADS];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rrs_wake_calc.sv =====
module rrs_wake_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] ms,
    input  logic [16:0] rate,
    output logic        done,
    output logic [31:0] quot
);

    logic [1:0]  vld_reg;
    logic [32:0] prod_reg;
    logic [23:0] quot_reg;
    logic [60:0] scaled;

    // The product is below 2^33, so after the shift by 3 it fits 30 bits.
    assign scaled = {31'b0, prod_reg[32:3]} * {30'b0, rrs_pkg::MS_RECIP};
    assign done   = vld_reg[1];
    assign quot   = {8'b0, quot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[0], start};
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= {17'b0, ms} * {16'b0, rate};
        if (vld_reg[0])
            quot_reg <= scaled[60:37];
    end

endmodule

// ===== design/rrs_ctrl.sv =====
module rrs_ctrl #(
    parameter int MAX_THREADS = 16,
    parameter int SW          = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             opcode,
    input  logic [3:0]             slot,
    input  logic [15:0]            sleep_ms,
    input  logic [31:0]            now_ticks,
    input  logic                   switch_inhibit,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             current_slot,
    output logic                   switched,
    output logic                   start_fresh,
    output logic [3:0]             new_slot,
    output logic [1:0]             status_code,
    input  logic [7:0]             quantum_ticks,
    output logic [SW-1:0]          rd_addr,
    input  rrs_pkg::thread_state_t rd_state,
    input  logic [SW-1:0]          rd_fwd,
    input  logic [SW-1:0]          rd_bwd,
    input  logic [31:0]            wk_rdata,
    output logic                   wr_en,
    output logic [SW-1:0]          wr_addr,
    output rrs_pkg::field_mask_t   wr_mask,
    output rrs_pkg::thread_state_t wr_state,
    output logic [SW-1:0]          wr_fwd,
    output logic [SW-1:0]          wr_bwd,
    output logic                   wk_we,
    output logic [31:0]            wk_wdata,
    output logic                   div_start,
    output logic [15:0]            div_ms,
    input  logic                   div_done,
    input  logic [31:0]            div_quot
);

    localparam int LIMIT  = MAX_THREADS * (MAX_THREADS + 1);
    localparam int STEP_W = $clog2(LIMIT + 1);
    localparam int N_W    = $clog2(MAX_THREADS + 1);

    rrs_pkg::ctrl_state_t   st_reg, st_next;
    rrs_pkg::opcode_t       op_reg, op_next;
    rrs_pkg::thread_state_t u_state_reg, u_state_next;
    rrs_pkg::status_t       status_reg, status_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [7:0]        quant_reg, quant_next;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     t_reg, t_next;
    logic [SW-1:0]     nxt_reg, nxt_next;
    logic [SW-1:0]     f_reg, f_next;
    logic [SW-1:0]     b_reg, b_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic              zomb_reg, zomb_next;
    logic [15:0]       ms_reg, ms_next;
    logic [31:0]       now_reg, now_next;
    logic              inh_reg, inh_next;
    logic              switched_reg, switched_next;
    logic              fresh_reg, fresh_next;
    logic [SW-1:0]     new_slot_reg, new_slot_next;
    logic [3:0]        o_cur_reg, o_cur_next;
    logic              o_sw_reg, o_sw_next;
    logic              o_fresh_reg, o_fresh_next;
    logic [3:0]        o_new_reg, o_new_next;
    logic [1:0]        o_status_reg, o_status_next;
    logic [7:0]        qload;
    logic [STEP_W-1:0] steps_inc;
    logic              slot_ok;

    assign qload     = (quantum_ticks == 8'd0) ? 8'd1 : quantum_ticks;
    assign steps_inc = steps_reg + 1'b1;
    assign slot_ok   = 32'(slot) < MAX_THREADS;

    always_comb
    begin
        st_next        = st_reg;
        op_next        = op_reg;
        u_state_next   = u_state_reg;
        status_next    = status_reg;
        cur_next       = cur_reg;
        quant_next     = quant_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        nxt_next       = nxt_reg;
        f_next         = f_reg;
        b_next         = b_reg;
        steps_next     = steps_reg;
        n_next         = n_reg;
        zomb_next      = zomb_reg;
        ms_next        = ms_reg;
        now_next       = now_reg;
        inh_next       = inh_reg;
        switched_next  = switched_reg;
        fresh_next     = fresh_reg;
        new_slot_next  = new_slot_reg;
        o_cur_next     = o_cur_reg;
        o_sw_next      = o_sw_reg;
        o_fresh_next   = o_fresh_reg;
        o_new_next     = o_new_reg;
        o_status_next  = o_status_reg;
        in_ready       = 1'b0;
        rd_addr        = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = t_reg;
        wr_mask        = '0;
        wr_state       = rrs_pkg::ST_RUNNING;
        wr_fwd         = t_reg;
        wr_bwd         = t_reg;
        wk_we          = 1'b0;
        wk_wdata       = now_reg + div_quot;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (st_reg)
            rrs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = rrs_pkg::opcode_t'(opcode);
                    ms_next       = sleep_ms;
                    now_next      = now_ticks;
                    inh_next      = switch_inhibit;
                    status_next   = rrs_pkg::STAT_OK;
                    switched_next = 1'b0;
                    fresh_next    = 1'b0;
                    new_slot_next = '0;
                    t_next        = SW'(slot);
                    unique case (opcode)
                        rrs_pkg::OP_TICK:  st_next = rrs_pkg::S_T_RDC;
                        rrs_pkg::OP_SPAWN:
                        begin
                            t_next  = '0;
                            st_next = rrs_pkg::S_SP_RD;
                        end
                        rrs_pkg::OP_KILL, rrs_pkg::OP_WAKE:
                        begin
                            if (slot_ok)
                                st_next = rrs_pkg::S_TGT_RD;
                            else
                            begin
                                status_next = rrs_pkg::STAT_NOT_USED;
                                st_next     = rrs_pkg::S_FIN;
                            end
                        end
                        rrs_pkg::OP_SLEEP, rrs_pkg::OP_PAUSE: st_next = rrs_pkg::S_CUR_RD;
                        default: st_next = rrs_pkg::S_FIN;
                    endcase
                end
            end

            rrs_pkg::S_T_RDC:
            begin
                rd_addr = cur_reg;
                st_next = rrs_pkg::S_T_FIRST;
            end

            rrs_pkg::S_T_FIRST:
            begin
                t_next     = rd_fwd;
                steps_next = '0;
                st_next    = rrs_pkg::S_T_RD;
            end

            rrs_pkg::S_T_RD:
            begin
                rd_addr = t_reg;
                st_next = rrs_pkg::S_T_EV;
            end

            rrs_pkg::S_T_EV:
            begin
                nxt_next = rd_fwd;
                f_next   = rd_fwd;
                b_next   = rd_bwd;
                st_next  = rrs_pkg::S_T_NEXT;
                unique case (rd_state)
                    rrs_pkg::ST_SLEEPING:
                    begin
                        if (now_reg > wk_rdata)
                        begin
                            quant_next = '0;
                            if (t_reg == cur_reg)
                            begin
                                wr_en    = 1'b1;
                                wr_mask  = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                                wr_state = rrs_pkg::ST_RUNNING;
                            end
                            else
                            begin
                                u_state_next = rrs_pkg::ST_RUNNING;
                                zomb_next    = 1'b0;
                                st_next      = rrs_pkg::S_UL_B;
                            end
                        end
                    end
                    rrs_pkg::ST_ZOMBIE:
                    begin
                        if (t_reg == cur_reg)
                        begin
                            // Alone in the ring with nothing to run.
                            status_next = rrs_pkg::STAT_DEAD;
                            quant_next  = '0;
                        end
                        else
                        begin
                            u_state_next = rrs_pkg::ST_FREE;
                            zomb_next    = 1'b1;
                            st_next      = rrs_pkg::S_UL_B;
                        end
                    end
                    default: ;
                endcase
            end

            rrs_pkg::S_T_NEXT:
            begin
                t_next     = nxt_reg;
                steps_next = steps_inc;
                if (nxt_reg != cur_reg && steps_inc < STEP_W'(LIMIT))
                    st_next = rrs_pkg::S_T_RD;
                else
                    st_next = rrs_pkg::S_QUANT;
            end

            rrs_pkg::S_UL_B:
            begin
                wr_en   = 1'b1;
                wr_addr = f_reg;
                wr_mask = '{st: 1'b0, fwd: 1'b0, bwd: 1'b1};
                wr_bwd  = b_reg;
                st_next = rrs_pkg::S_UL_F;
            end

            rrs_pkg::S_UL_F:
            begin
                wr_en   = 1'b1;
                wr_addr = b_reg;
                wr_mask = '{st: 1'b0, fwd: 1'b1, bwd: 1'b0};
                wr_fwd  = f_reg;
                st_next = rrs_pkg::S_UL_S;
            end

            rrs_pkg::S_UL_S:
            begin
                wr_en    = 1'b1;
                wr_addr  = t_reg;
                wr_mask  = '{st: 1'b1, fwd: 1'b1, bwd: 1'b1};
                wr_state = u_state_reg;
                st_next  = zomb_reg ? rrs_pkg::S_T_NEXT : rrs_pkg::S_IN_RDC;
            end

            rrs_pkg::S_IN_RDC:
            begin
                rd_addr = cur_reg;
                st_next = rrs_pkg::S_IN_F;
            end

            rrs_pkg::S_IN_F:
            begin
                f_next  = rd_fwd;
                wr_en   = 1'b1;
                wr_mask = '{st: 1'b0, fwd: 1'b1, bwd: 1'b0};
                wr_fwd  = rd_fwd;
                st_next = rrs_pkg::S_IN_BF;
            end

            rrs_pkg::S_IN_BF:
            begin
                wr_en   = 1'b1;
                wr_addr = f_reg;
                wr_mask = '{st: 1'b0, fwd: 1'b0, bwd: 1'b1};
                wr_bwd  = t_reg;
                st_next = rrs_pkg::S_IN_BS;
            end

            rrs_pkg::S_IN_BS:
            begin
                wr_en   = 1'b1;
                wr_mask = '{st: 1'b0, fwd: 1'b0, bwd: 1'b1};
                wr_bwd  = cur_reg;
                st_next = rrs_pkg::S_IN_FC;
            end

            rrs_pkg::S_IN_FC:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_mask = '{st: 1'b0, fwd: 1'b1, bwd: 1'b0};
                wr_fwd  = t_reg;
                // A promoted sleeper continues the walk from its new neighbor.
                if (op_reg == rrs_pkg::OP_TICK)
                begin
                    nxt_next = f_reg;
                    st_next  = rrs_pkg::S_T_NEXT;
                end
                else
                    st_next = rrs_pkg::S_FIN;
            end

            rrs_pkg::S_QUANT:
            begin
                if (quant_reg == 8'd0)
                begin
                    quant_next = qload - 8'd1;
                    st_next    = inh_reg ? rrs_pkg::S_FIN : rrs_pkg::S_SW_RDC;
                end
                else
                begin
                    quant_next = quant_reg - 8'd1;
                    st_next    = rrs_pkg::S_FIN;
                end
            end

            rrs_pkg::S_SW_RDC:
            begin
                rd_addr = cur_reg;
                st_next = rrs_pkg::S_SW_FIRST;
            end

            rrs_pkg::S_SW_FIRST:
            begin
                t_next  = rd_fwd;
                n_next  = '0;
                st_next = (rd_fwd == cur_reg) ? rrs_pkg::S_FIN : rrs_pkg::S_SW_RD;
            end

            rrs_pkg::S_SW_RD:
            begin
                rd_addr = t_reg;
                st_next = rrs_pkg::S_SW_EV;
            end

            rrs_pkg::S_SW_EV:
            begin
                priority if (t_reg == cur_reg)
                    st_next = rrs_pkg::S_FIN;
                else if (rd_state == rrs_pkg::ST_RUNNING || rd_state == rrs_pkg::ST_READY)
                begin
                    if (rd_state == rrs_pkg::ST_READY)
                    begin
                        wr_en      = 1'b1;
                        wr_mask    = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                        wr_state   = rrs_pkg::ST_RUNNING;
                        fresh_next = 1'b1;
                    end
                    cur_next      = t_reg;
                    switched_next = 1'b1;
                    st_next       = rrs_pkg::S_FIN;
                end
                else if (n_reg == N_W'(MAX_THREADS))
                    st_next = rrs_pkg::S_FIN;
                else
                begin
                    t_next  = rd_fwd;
                    n_next  = n_reg + 1'b1;
                    st_next = rrs_pkg::S_SW_RD;
                end
            end

            rrs_pkg::S_SP_RD:
            begin
                rd_addr = t_reg;
                st_next = rrs_pkg::S_SP_EV;
            end

            rrs_pkg::S_SP_EV:
            begin
                priority if (rd_state == rrs_pkg::ST_FREE)
                begin
                    new_slot_next = t_reg;
                    wr_en         = 1'b1;
                    wr_mask       = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                    wr_state      = rrs_pkg::ST_READY;
                    st_next       = rrs_pkg::S_IN_RDC;
                end
                else if (t_reg == SW'(MAX_THREADS - 1))
                begin
                    status_next = rrs_pkg::STAT_NO_FREE;
                    st_next     = rrs_pkg::S_FIN;
                end
                else
                begin
                    t_next  = t_reg + 1'b1;
                    st_next = rrs_pkg::S_SP_RD;
                end
            end

            rrs_pkg::S_TGT_RD:
            begin
                rd_addr = t_reg;
                st_next = (op_reg == rrs_pkg::OP_KILL) ? rrs_pkg::S_KILL_EV
                                                       : rrs_pkg::S_WAKE_EV;
            end

            rrs_pkg::S_KILL_EV:
            begin
                st_next = rrs_pkg::S_FIN;
                if (rd_state == rrs_pkg::ST_FREE)
                    status_next = rrs_pkg::STAT_NOT_USED;
                else
                begin
                    wr_en    = 1'b1;
                    wr_mask  = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                    wr_state = rrs_pkg::ST_ZOMBIE;
                    if (t_reg == cur_reg)
                        quant_next = '0;
                end
            end

            rrs_pkg::S_WAKE_EV:
            begin
                st_next = rrs_pkg::S_FIN;
                f_next  = rd_fwd;
                b_next  = rd_bwd;
                priority if (rd_state == rrs_pkg::ST_FREE)
                    status_next = rrs_pkg::STAT_NOT_USED;
                else if (rd_state == rrs_pkg::ST_PAUSED || rd_state == rrs_pkg::ST_SLEEPING)
                begin
                    if (t_reg == cur_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_mask  = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                        wr_state = rrs_pkg::ST_RUNNING;
                    end
                    else
                    begin
                        u_state_next = rrs_pkg::ST_RUNNING;
                        zomb_next    = 1'b0;
                        quant_next   = '0;
                        st_next      = rrs_pkg::S_UL_B;
                    end
                end
                else
                    st_next = rrs_pkg::S_FIN;
            end

            rrs_pkg::S_CUR_RD:
            begin
                rd_addr = cur_reg;
                st_next = rrs_pkg::S_CUR_EV;
            end

            rrs_pkg::S_CUR_EV:
            begin
                priority if (rd_state != rrs_pkg::ST_RUNNING)
                begin
                    status_next = rrs_pkg::STAT_NOT_USED;
                    st_next     = rrs_pkg::S_FIN;
                end
                else if (op_reg == rrs_pkg::OP_PAUSE)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = cur_reg;
                    wr_mask    = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                    wr_state   = rrs_pkg::ST_PAUSED;
                    quant_next = '0;
                    st_next    = rrs_pkg::S_FIN;
                end
                else
                begin
                    div_start = 1'b1;
                    st_next   = rrs_pkg::S_DIV_WAIT;
                end
            end

            rrs_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = cur_reg;
                    wr_mask    = '{st: 1'b1, fwd: 1'b0, bwd: 1'b0};
                    wr_state   = rrs_pkg::ST_SLEEPING;
                    wk_we      = 1'b1;
                    quant_next = '0;
                    st_next    = rrs_pkg::S_FIN;
                end
            end

            rrs_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_cur_next     = 4'(cur_reg);
                    o_sw_next      = switched_reg;
                    o_fresh_next   = fresh_reg;
                    o_new_next     = 4'(new_slot_reg);
                    o_status_next  = status_reg;
                    st_next        = rrs_pkg::S_IDLE;
                end
            end

            default: st_next = rrs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= rrs_pkg::S_IDLE;
            cur_reg       <= '0;
            quant_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cur_reg       <= cur_next;
            quant_reg     <= quant_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        u_state_reg  <= u_state_next;
        status_reg   <= status_next;
        t_reg        <= t_next;
        nxt_reg      <= nxt_next;
        f_reg        <= f_next;
        b_reg        <= b_next;
        steps_reg    <= steps_next;
        n_reg        <= n_next;
        zomb_reg     <= zomb_next;
        ms_reg       <= ms_next;
        now_reg      <= now_next;
        inh_reg      <= inh_next;
        switched_reg <= switched_next;
        fresh_reg    <= fresh_next;
        new_slot_reg <= new_slot_next;
        o_cur_reg    <= o_cur_next;
        o_sw_reg     <= o_sw_next;
        o_fresh_reg  <= o_fresh_next;
        o_new_reg    <= o_new_next;
        o_status_reg <= o_status_next;
    end

    assign div_ms       = ms_reg;
    assign out_valid    = out_valid_reg;
    assign current_slot = o_cur_reg;
    assign switched     = o_sw_reg;
    assign start_fresh  = o_fresh_reg;
    assign new_slot     = o_new_reg;
    assign status_code  = o_status_reg;

`ifndef SYNTHESIS
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> st_reg != rrs_pkg::S_IDLE)
        else $error("accepted transfer did not start work");

    a_cur_changes_on_switch: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cur_reg) |-> $past(st_reg) == rrs_pkg::S_SW_EV)
        else $error("current slot changed outside a switch");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == rrs_pkg::S_T_RD |-> steps_reg < STEP_W'(LIMIT))
        else $error("ring walk ran past its bound");

    a_div_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> st_reg == rrs_pkg::S_DIV_WAIT)
        else $error("wake time division started without a wait");
`endif

endmodule
